/* rtl/core/grt_pkg.sv */
// grt_pkg: shared constants and types for the grid ray traversal core
// no dependencies; imported by grt_div and grid_ray_traversal_core
package grt_pkg;

  localparam int MapSide  = 32;
  localparam int MapBits  = $clog2(MapSide);
  localparam int TileBits = 4;
  localparam int CellBits = 14;  // signed cell index, holds -1 .. MapSide<<7
  localparam int LenBits  = 20;

  localparam logic [LenBits-1:0] StepSat = 20'h7FFFF;
  localparam logic signed [CellBits-1:0] CellLimit = CellBits'(MapSide << 7);

  // configuration register indexes
  localparam logic [1:0] CfgCellLog2 = 2'd0;
  localparam logic [1:0] CfgColumns  = 2'd1;
  localparam logic [1:0] CfgRows     = 2'd2;
  localparam logic [1:0] CfgMaxDist  = 2'd3;

  // input commands
  localparam logic CmdWriteTile = 1'b0;
  localparam logic CmdCast      = 1'b1;

  typedef logic [LenBits-1:0] len_t;

endpackage

/* rtl/core/grid_ray_traversal_core.sv */
// grid_ray_traversal_core: DDA ray walk over a tile map held in a 1024x4 memory
// depends on grt_pkg and grt_div
//
//  channel | direction | handshake            | payload
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in        | in_valid/in_stall    | command, tile, start, dir fields
//  out     | out       | out_valid/out_stall  | hit, hit_tile, hit_side, distance, point
//
// a write-tile transfer is taken while idle; a cast runs the step-length division,
// edge setup, one cell walked per cycle (tile read is overlapped with the next step),
// a further check of the last read, then a product and a sum stage for the hit point
// when there is a hit, and then the send, which waits while the receiver stalls.
// the walk is bounded by max_walk_distance; a unit direction crosses at most about
// 1.42 cells per unit, near 2900 cells at the top setting.
// reset is asynchronous active low; no clearing pass, tiles must be written first.
// a finished result waits in the output register while new items are taken.
module grid_ray_traversal_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [10:0]                       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [4:0]                        tile_column_i,
  input  logic [4:0]                        tile_row_i,
  input  logic [grt_pkg::TileBits-1:0]      tile_value_i,
  input  logic [17:0]                       start_x_i,
  input  logic [17:0]                       start_y_i,
  input  logic signed [15:0]                dir_x_i,
  input  logic signed [15:0]                dir_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o,
  output logic [grt_pkg::TileBits-1:0]      hit_tile_o,
  output logic                              hit_side_o,
  output logic [19:0]                       hit_distance_o,
  output logic signed [19:0]                hit_x_o,
  output logic signed [19:0]                hit_y_o
);
  import grt_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StSide = 3'd2;
  localparam logic [2:0] StWalk = 3'd3;
  localparam logic [2:0] StProd = 3'd4;
  localparam logic [2:0] StSum  = 3'd5;
  localparam logic [2:0] StSend = 3'd6;

  logic [2:0] state_q, state_d;

  // configuration
  logic [2:0]  csl_q;
  logic [5:0]  cols_q, rows_q;
  logic [10:0] maxd_q;
  logic [5:0]  cols_b, rows_b;
  logic [18:0] limit;

  // cast operands
  logic [17:0]        sx_q, sy_q;
  logic signed [15:0] dx_q, dy_q;
  len_t               lx_q, ly_q;

  // walk state
  logic signed [CellBits-1:0] cx_q, cy_q, nx, ny;
  len_t  sidex_q, sidey_q, dist_q;
  logic  side_q, pend_q, hit_q;
  logic [TileBits-1:0] tile_q, rd_q;
  logic  stepx, inb, hit_now, walk_step;
  logic [CellBits-1:0] tc, tr;

  // tile memory
  logic [TileBits-1:0] mem [MapSide*MapSide];

  // divider
  logic        div_go, done_x, done_y;
  len_t        qx, qy;
  logic [15:0] ax, ay;

  // finishing
  logic [8:0]  gapx, gapy;
  logic [28:0] fsx, fsy;
  logic signed [36:0] px, py;
  logic signed [36:0] px_q, py_q;
  logic signed [23:0] spx, spy;
  logic signed [19:0] hx_q, hy_q;

  // output register
  logic               ov_q, ohit_q, oside_q;
  logic [TileBits-1:0] otile_q;
  logic [19:0]        odist_q;
  logic signed [19:0] ox_q, oy_q;
  logic               send;

  function automatic logic signed [CellBits-1:0] move_cell(
    input logic signed [CellBits-1:0] c, input logic neg);
    logic signed [CellBits:0] s;
    s = (CellBits+1)'(c);
    s = neg ? s - (CellBits+1)'(1) : s + (CellBits+1)'(1);
    if (s < (CellBits+1)'(-1)) begin
      return CellBits'(-1);
    end else if (s > (CellBits+1)'(CellLimit)) begin
      return CellLimit;
    end
    return s[CellBits-1:0];
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [23:0] v);
    if (v > 24'sd524287) begin
      return 20'sh7FFFF;
    end else if (v < -24'sd524288) begin
      return 20'sh80000;
    end
    return v[19:0];
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != StIdle;
  assign cols_b = (cols_q > 6'(MapSide)) ? 6'(MapSide) : cols_q;
  assign rows_b = (rows_q > 6'(MapSide)) ? 6'(MapSide) : rows_q;
  assign limit  = {maxd_q, 8'd0};

  assign div_go = in_valid_i && !in_stall_o && command_i == CmdCast;
  assign ax = dir_x_i[15] ? 16'(-dir_x_i) : dir_x_i;
  assign ay = dir_y_i[15] ? 16'(-dir_y_i) : dir_y_i;

  grt_div u_div_x (
    .clk_i, .rst_ni, .start_i(div_go), .divisor_i(ax), .done_o(done_x), .quot_o(qx)
  );
  grt_div u_div_y (
    .clk_i, .rst_ni, .start_i(div_go), .divisor_i(ay), .done_o(done_y), .quot_o(qy)
  );

  // first edge distances
  assign gapx = dx_q[15] ? {1'b0, sx_q[7:0]} : 9'd256 - {1'b0, sx_q[7:0]};
  assign gapy = dy_q[15] ? {1'b0, sy_q[7:0]} : 9'd256 - {1'b0, sy_q[7:0]};
  assign fsx  = gapx * lx_q;
  assign fsy  = gapy * ly_q;

  // one DDA step; ties go along y
  assign stepx = sidex_q < sidey_q;
  assign nx = stepx ? move_cell(cx_q, dx_q[15]) : cx_q;
  assign ny = stepx ? cy_q : move_cell(cy_q, dy_q[15]);
  assign tc = CellBits'($unsigned(nx) >> csl_q);
  assign tr = CellBits'($unsigned(ny) >> csl_q);
  assign inb = !nx[CellBits-1] && !ny[CellBits-1] &&
               tc < CellBits'(cols_b) && tr < CellBits'(rows_b);
  assign hit_now   = pend_q && rd_q != '0;
  assign walk_step = state_q == StWalk && !hit_now && {1'b0, limit} > dist_q;

  assign px  = dx_q * $signed({1'b0, dist_q});
  assign py  = dy_q * $signed({1'b0, dist_q});
  // floor division by 2^14 is an arithmetic shift
  assign spx = $signed({6'd0, sx_q}) + 24'($signed(px_q[36:14]));
  assign spy = $signed({6'd0, sy_q}) + 24'($signed(py_q[36:14]));

  assign send = state_q == StSend && (!ov_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (div_go) state_d = StDiv;
      StDiv:  if (done_x) state_d = StSide;
      StSide: state_d = StWalk;
      StWalk: begin
        if (hit_now) begin
          state_d = StProd;
        end else if (!walk_step) begin
          state_d = StSend;
        end
      end
      StProd: state_d = StSum;
      StSum:  state_d = StSend;
      StSend: if (send) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      csl_q   <= 3'd5;
      cols_q  <= 6'd24;
      rows_q  <= 6'd24;
      maxd_q  <= 11'd1000;
      ov_q    <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgCellLog2: csl_q  <= cfg_data_i[2:0];
          CfgColumns:  cols_q <= cfg_data_i[5:0];
          CfgRows:     rows_q <= cfg_data_i[5:0];
          CfgMaxDist:  maxd_q <= cfg_data_i;
          default:     ;
        endcase
      end
      if (send) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
      if (state_q == StSide) begin
        pend_q <= 1'b0;
      end else if (walk_step) begin
        pend_q <= inb;
      end
    end
  end

  // tile memory: writes only while idle, reads only while walking, so no overlap
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o && command_i == CmdWriteTile) begin
      mem[{tile_row_i[MapBits-1:0], tile_column_i[MapBits-1:0]}] <= tile_value_i;
    end
    if (walk_step && inb) begin
      rd_q <= mem[{tr[MapBits-1:0], tc[MapBits-1:0]}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_go) begin
      sx_q <= start_x_i;
      sy_q <= start_y_i;
      dx_q <= dir_x_i;
      dy_q <= dir_y_i;
    end
    if (state_q == StDiv && done_x) begin
      lx_q <= qx;
      ly_q <= qy;
    end
    if (state_q == StSide) begin
      sidex_q <= fsx[27:8];
      sidey_q <= fsy[27:8];
      cx_q    <= $signed(CellBits'(sx_q[17:8]));
      cy_q    <= $signed(CellBits'(sy_q[17:8]));
      dist_q  <= '0;
      side_q  <= 1'b0;
      hit_q   <= 1'b0;
      tile_q  <= '0;
      hx_q    <= '0;
      hy_q    <= '0;
    end
    if (walk_step) begin
      cx_q <= nx;
      cy_q <= ny;
      if (stepx) begin
        dist_q  <= sidex_q;
        sidex_q <= sidex_q + lx_q;
        side_q  <= 1'b0;
      end else begin
        dist_q  <= sidey_q;
        sidey_q <= sidey_q + ly_q;
        side_q  <= 1'b1;
      end
    end
    if (state_q == StWalk && hit_now) begin
      hit_q  <= 1'b1;
      tile_q <= rd_q;
    end
    if (state_q == StProd) begin
      px_q <= px;
      py_q <= py;
    end
    if (state_q == StSum) begin
      hx_q <= sat20(spx);
      hy_q <= sat20(spy);
    end
    if (send) begin
      ohit_q  <= hit_q;
      otile_q <= tile_q;
      oside_q <= side_q;
      odist_q <= dist_q;
      ox_q    <= hx_q;
      oy_q    <= hy_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign hit_o          = ohit_q;
  assign hit_tile_o     = otile_q;
  assign hit_side_o     = oside_q;
  assign hit_distance_o = odist_q;
  assign hit_x_o        = ox_q;
  assign hit_y_o        = oy_q;

`ifndef NO_ASSERTIONS
  a_nohit_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> hit_tile_o == '0 && hit_x_o == '0 && hit_y_o == '0)
    else $error("no-hit result carries tile or point");

  a_cast_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_go |=> state_q == StDiv)
    else $error("cast transfer did not start division");

  a_cell_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWalk |-> cx_q >= CellBits'(-1) && cx_q <= CellLimit &&
                          cy_q >= CellBits'(-1) && cy_q <= CellLimit)
    else $error("walk cell out of range");

  a_div_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_x == done_y)
    else $error("dividers out of step");

  a_send_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    send |=> state_q == StIdle && out_valid_o)
    else $error("result not loaded");
`endif

endmodule

/* rtl/core/grt_div.sv */
// grt_div: restoring divider, one quotient bit per cycle, computes 2^22 / divisor
// saturated to the step length range; depends on grt_pkg
module grt_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [15:0]       divisor_i,
  output logic              done_o,
  output grt_pkg::len_t     quot_o
);
  import grt_pkg::*;

  logic [15:0] div_q;
  logic [15:0] rem_q, rem_d;
  logic [22:0] quo_q;
  logic [4:0]  cnt_q;
  logic        run_q, done_q;
  logic [16:0] trial;
  logic        ge;

  // the dividend has a single one at bit 22
  assign trial = {rem_q, (cnt_q == 5'd22)};
  assign ge    = trial >= {1'b0, div_q};
  assign rem_d = ge ? 16'(trial - {1'b0, div_q}) : trial[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 5'd22;
      end else if (run_q) begin
        if (cnt_q == 5'd0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[21:0], ge};
    end
  end

  // a zero divisor yields all ones, which saturates as well
  assign quot_o = (|quo_q[22:19]) ? StepSat : quo_q[19:0];
  assign done_o = done_q;

endmodule
